[src/lrpd_pkg.sv]
// Shared types, character codes and helpers for the lr parameter detector.
`timescale 1ns / 1ps
`default_nettype none

package lrpd_pkg;

    // Recognizer phases, one-hot
    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_SEEN_L = 7'b0000010,
        PH_SEEN_LR = 7'b0000100,
        PH_LR_WS  = 7'b0001000,
        PH_OTHER  = 7'b0010000,
        PH_QUOTE  = 7'b0100000,
        PH_ESCAPE = 7'b1000000
    } phase_t;

    // Recognizer state carried from byte to byte
    typedef struct packed {
        phase_t phase;
        logic   lr_found;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{phase: PH_START, lr_found: 1'b0};

    localparam logic [7:0] CH_LOWER_L  = 8'h6C;
    localparam logic [7:0] CH_UPPER_L  = 8'h4C;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CH_UPPER_R  = 8'h52;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;

    // Space, CR, LF or tab
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

[src/lrpd_stream_if.sv]
// Valid/ready channel interfaces for the character stream and the verdict stream.
`timescale 1ns / 1ps
`default_nettype none

interface lrpd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       has_char;
    logic       end_of_string;

    modport source (output valid, output char_in, output has_char,
                    output end_of_string, input ready);
    modport sink   (input valid, input char_in, input has_char,
                    input end_of_string, output ready);
endinterface

interface lrpd_verdict_if;
    logic valid;
    logic ready;
    logic strict_router;

    modport source (output valid, output strict_router, input ready);
    modport sink   (input valid, input strict_router, output ready);
endinterface

`default_nettype wire

[src/lrpd_scan.sv]
// Next-state and verdict logic of the lr parameter recognizer for one byte.
`timescale 1ns / 1ps
`default_nettype none

module lrpd_scan (
    input  wire lrpd_pkg::scan_state_t cur,
    input  wire logic [7:0]            char_in,
    input  wire logic                  has_char,
    input  wire logic                  end_of_string,
    output lrpd_pkg::scan_state_t      nxt,
    output logic                       strict_router
);

    lrpd_pkg::scan_state_t scanned;

    // Advance the recognizer by one byte; bytes after the decision are dropped
    always_comb
    begin
        scanned = cur;
        if (has_char && !cur.lr_found)
        begin
            unique case (cur.phase)
                lrpd_pkg::PH_START:
                begin
                    if (!lrpd_pkg::is_ws(char_in))
                    begin
                        if (char_in == lrpd_pkg::CH_LOWER_L || char_in == lrpd_pkg::CH_UPPER_L)
                            scanned.phase = lrpd_pkg::PH_SEEN_L;
                        else
                            scanned.phase = lrpd_pkg::PH_OTHER;
                    end
                end
                lrpd_pkg::PH_SEEN_L:
                begin
                    if (char_in == lrpd_pkg::CH_LOWER_R || char_in == lrpd_pkg::CH_UPPER_R)
                        scanned.phase = lrpd_pkg::PH_SEEN_LR;
                    else
                        scanned.phase = lrpd_pkg::PH_OTHER;
                end
                lrpd_pkg::PH_SEEN_LR, lrpd_pkg::PH_LR_WS:
                begin
                    priority if (char_in == lrpd_pkg::CH_SEMI || char_in == lrpd_pkg::CH_EQUAL)
                        scanned.lr_found = 1'b1;
                    else if (lrpd_pkg::is_ws(char_in))
                        scanned.phase = lrpd_pkg::PH_LR_WS;
                    else
                        scanned.phase = lrpd_pkg::PH_OTHER;
                end
                lrpd_pkg::PH_OTHER:
                begin
                    priority if (char_in == lrpd_pkg::CH_DQUOTE)
                        scanned.phase = lrpd_pkg::PH_QUOTE;
                    else if (char_in == lrpd_pkg::CH_SEMI)
                        scanned.phase = lrpd_pkg::PH_START;
                    else
                        scanned.phase = lrpd_pkg::PH_OTHER;
                end
                lrpd_pkg::PH_QUOTE:
                begin
                    priority if (char_in == lrpd_pkg::CH_BSLASH)
                        scanned.phase = lrpd_pkg::PH_ESCAPE;
                    else if (char_in == lrpd_pkg::CH_DQUOTE)
                        scanned.phase = lrpd_pkg::PH_OTHER;
                    else
                        scanned.phase = lrpd_pkg::PH_QUOTE;
                end
                lrpd_pkg::PH_ESCAPE:
                begin
                    scanned.phase = lrpd_pkg::PH_QUOTE;
                end
                default:
                begin
                    scanned = cur;
                end
            endcase
        end
    end

    // Form the verdict from the scanned state; clear the state at end of string
    always_comb
    begin
        strict_router = !(scanned.lr_found ||
                          scanned.phase == lrpd_pkg::PH_SEEN_LR ||
                          scanned.phase == lrpd_pkg::PH_LR_WS);
        nxt = end_of_string ? lrpd_pkg::SCAN_RESET : scanned;
    end

endmodule

`default_nettype wire

[src/lr_param_detector_unit.sv]
// Throughput: one character word per cycle, limited by the single recognizer state update,
// unless an end-of-string word is staged while the output is stalled. The input register
// accepts a new word while a verdict waits on a stalled output, unless the staged word
// ends a string. Reset (rst_n low, asynchronous) empties both registers and returns the
// recognizer to the start of a parameter with no lr decision.
// Top level: input register, recognizer, verdict register.
`timescale 1ns / 1ps
`default_nettype none

module lr_param_detector_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lrpd_char_if.sink          chars,
    lrpd_verdict_if.source     verdict
);

    logic                  stg_valid_reg;
    logic [7:0]            stg_char_reg;
    logic                  stg_has_char_reg;
    logic                  stg_eos_reg;
    lrpd_pkg::scan_state_t state_reg;
    lrpd_pkg::scan_state_t state_next;
    logic                  strict_next;
    logic                  out_valid_reg;
    logic                  strict_reg;
    logic                  out_free;
    logic                  advance;

    // Process the staged word unless its verdict cannot be placed
    assign out_free      = !out_valid_reg || verdict.ready;
    assign advance       = stg_valid_reg && (!stg_eos_reg || out_free);
    assign chars.ready   = !stg_valid_reg || advance;
    assign verdict.valid = out_valid_reg;
    assign verdict.strict_router = strict_reg;

    lrpd_scan u_scan (
        .cur           (state_reg),
        .char_in       (stg_char_reg),
        .has_char      (stg_has_char_reg),
        .end_of_string (stg_eos_reg),
        .nxt           (state_next),
        .strict_router (strict_next)
    );

    // Input register: load a word whenever the stage is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (chars.ready)
            stg_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            stg_char_reg     <= chars.char_in;
            stg_has_char_reg <= chars.has_char;
            stg_eos_reg      <= chars.end_of_string;
        end
    end

    // Recognizer state: advance once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lrpd_pkg::SCAN_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // Verdict register: load at end of string, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && stg_eos_reg)
            out_valid_reg <= 1'b1;
        else if (verdict.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && stg_eos_reg)
            strict_reg <= strict_next;
    end

`ifndef SYNTHESIS
    // The decision is only ever taken right after lr
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.lr_found |-> (state_reg.phase == lrpd_pkg::PH_SEEN_LR ||
                                state_reg.phase == lrpd_pkg::PH_LR_WS))
    else $error("lr decision held outside the lr phases");

    // The end of a string returns the recognizer to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_eos_reg |=> state_reg == lrpd_pkg::SCAN_RESET)
    else $error("recognizer not cleared after end of string");

    // A processed end-of-string word always produces a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_eos_reg |=> out_valid_reg)
    else $error("verdict missing after end of string");

    // A decided string gives loose
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_eos_reg && state_reg.lr_found |=> !strict_reg)
    else $error("decided lr string reported strict");
`endif

endmodule

`default_nettype wire
